// ===== rtl/core/pbfs_pkg.sv =====
`default_nettype none
package pbfs_pkg;

    // field widths
    localparam int FREQ_W  = 13;
    localparam int POWER_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // shared multiplier and accumulator widths
    localparam int A_W   = 41;
    localparam int B_W   = 21;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = 80;
    localparam int HALF_SH = 20;

    localparam int DEFAULT_MAX_STEPS = 64;

    // register reset values
    localparam logic [FREQ_W-1:0]  RST_FREQ_A  = 13'd1000;
    localparam logic [POWER_W-1:0] RST_POWER_A = 20'd512;
    localparam logic [FREQ_W-1:0]  RST_FREQ_B  = 13'd4000;
    localparam logic [POWER_W-1:0] RST_POWER_B = 20'd1024;
    localparam logic [FREQ_W-1:0]  RST_MIN     = 13'd1000;
    localparam logic [FREQ_W-1:0]  RST_MAX     = 13'd4000;
    localparam logic [FREQ_W-1:0]  RST_STEP    = 13'd100;
    localparam logic [FREQ_W-1:0]  RST_CAP     = 13'd4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_A  = 3'd0,
        REG_POWER_A = 3'd1,
        REG_FREQ_B  = 3'd2,
        REG_POWER_B = 3'd3,
        REG_MIN     = 3'd4,
        REG_MAX     = 3'd5,
        REG_STEP    = 3'd6,
        REG_CAP     = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FC2,
        S_FC3,
        S_DYN0,
        S_DYN1,
        S_BASE,
        S_CHK,
        S_F2,
        S_F3,
        S_ROOM,
        S_L0,
        S_L1,
        S_R0,
        S_R1,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/power_budget_frequency_select.sv =====
// Power-budget frequency selector.
// Input beats on s_axis (tdata: current_freq_mhz, measured_power, power_budget)
// are taken only while the block is idle. Each beat gives exactly one result
// beat on m_axis: tdata holds chosen_freq_mhz, tuser holds budget_met.
// Configuration registers are written through cfg_valid/cfg_ready, cfg_index
// selecting the register; writes are always taken.
// All arithmetic runs through one 41x21 signed multiplier with an 80-bit
// accumulator under a small sequencer. Set-up runs through FC2, FC3, DYN0,
// DYN1 and BASE; then each grid step runs CHK, F2, F3, ROOM, L0, L1, R0 and
// R1 (cube of the candidate, static power, two double-length products and a
// compare), and only CHK, F2, F3 and ROOM when the step is over budget on
// static power alone. A final CHK and the output load in OUT end the item,
// and the block returns to idle before it takes the next beat: one item at a
// time.
// The result sits in an output register; if the receiver stalls, the next
// item may still be taken and runs up to its result, then waits until the
// register is free.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, drops the
// output beat and loads the configuration registers with their defaults.
`default_nettype none
module power_budget_frequency_select #(
    parameter int MAX_STEPS = pbfs_pkg::DEFAULT_MAX_STEPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbfs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [12:0] current_freq_mhz, [32:13] measured_power, [52:33] power_budget
    input  wire logic [55:0] s_axis_tdata,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [12:0] chosen_freq_mhz
    output logic [15:0]      m_axis_tdata,
    // [0] budget_met
    output logic [0:0]       m_axis_tuser
);

    localparam int FW = pbfs_pkg::FREQ_W;
    localparam int PW = pbfs_pkg::POWER_W;
    localparam int AW = pbfs_pkg::A_W;
    localparam int BW = pbfs_pkg::B_W;
    localparam int PRW = pbfs_pkg::P_W;
    localparam int CW = pbfs_pkg::ACC_W;
    localparam int SH = pbfs_pkg::HALF_SH;
    localparam int K_W = $clog2(MAX_STEPS + 1);
    localparam logic [K_W-1:0] K_LAST = K_W'(MAX_STEPS);

    // configuration registers
    logic [FW-1:0] freq_a_reg, freq_b_reg, min_reg, max_reg, step_reg, cap_reg;
    logic [PW-1:0] power_a_reg, power_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_a_reg  <= pbfs_pkg::RST_FREQ_A;
            power_a_reg <= pbfs_pkg::RST_POWER_A;
            freq_b_reg  <= pbfs_pkg::RST_FREQ_B;
            power_b_reg <= pbfs_pkg::RST_POWER_B;
            min_reg     <= pbfs_pkg::RST_MIN;
            max_reg     <= pbfs_pkg::RST_MAX;
            step_reg    <= pbfs_pkg::RST_STEP;
            cap_reg     <= pbfs_pkg::RST_CAP;
        end
        else if (cfg_valid)
        begin
            unique case (pbfs_pkg::reg_idx_t'(cfg_index))
                pbfs_pkg::REG_FREQ_A:  freq_a_reg  <= cfg_data[FW-1:0];
                pbfs_pkg::REG_POWER_A: power_a_reg <= cfg_data[PW-1:0];
                pbfs_pkg::REG_FREQ_B:  freq_b_reg  <= cfg_data[FW-1:0];
                pbfs_pkg::REG_POWER_B: power_b_reg <= cfg_data[PW-1:0];
                pbfs_pkg::REG_MIN:     min_reg     <= cfg_data[FW-1:0];
                pbfs_pkg::REG_MAX:     max_reg     <= cfg_data[FW-1:0];
                pbfs_pkg::REG_STEP:    step_reg    <= cfg_data[FW-1:0];
                default:               cap_reg     <= cfg_data[FW-1:0];
            endcase
        end
    end

    // state and datapath registers
    pbfs_pkg::state_t state_reg, state_next;
    logic [FW-1:0]   fc_reg;
    logic [PW-1:0]   meas_reg, budget_reg;
    logic [38:0]     fc3_reg, f3_reg;
    logic [36:0]     dyn_reg, room_reg;
    logic signed [35:0] base_reg;
    logic signed [CW-1:0] acc_reg, lhs_reg;
    logic [FW+1:0]   f_reg;
    logic [K_W-1:0]  k_reg;
    logic [FW-1:0]   chosen_reg;
    logic            met_reg;
    logic            out_valid_reg;
    logic [FW-1:0]   out_freq_reg;
    logic            out_met_reg;

    // static line terms: den = |fb - fa| (1 if equal), sign folded into the slope term
    logic signed [FW:0]   d_diff;
    logic                 d_zero, d_neg;
    logic [FW-1:0]        den;
    logic signed [PW:0]   dpp;

    assign d_diff = $signed({1'b0, freq_b_reg}) - $signed({1'b0, freq_a_reg});
    assign d_zero = (d_diff == '0);
    assign d_neg  = d_diff[FW];
    assign den    = d_zero ? FW'(1) : (d_neg ? FW'(-d_diff) : FW'(d_diff));
    assign dpp    = $signed({1'b0, power_b_reg}) - $signed({1'b0, power_a_reg});

    // minus the signed slope factor at frequency x
    function automatic logic signed [FW:0] neg_slope(input logic [FW-1:0] x,
                                                     input logic [FW-1:0] fa,
                                                     input logic dz, input logic dn);
        logic signed [FW:0] diff;
        diff = $signed({1'b0, x}) - $signed({1'b0, fa});
        if (dz)
            return '0;
        return dn ? diff : -diff;
    endfunction

    logic [FW-1:0] f_cur;
    assign f_cur = f_reg[FW-1:0];

    // shared multiply-accumulate unit
    typedef enum logic [1:0] { ADD_ZERO, ADD_ACC, ADD_BASE } addend_t;

    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic                  mul_sh;
    addend_t               add_sel;
    logic signed [PRW-1:0] prod;
    logic signed [CW-1:0]  prod_ext, addend, mac_res;

    assign prod     = mul_a * mul_b;
    assign prod_ext = CW'(prod);

    always_comb
    begin
        case (add_sel)
            ADD_ACC:  addend = acc_reg;
            ADD_BASE: addend = CW'(base_reg);
            default:  addend = '0;
        endcase
        mac_res = addend + (mul_sh ? (prod_ext <<< SH) : prod_ext);
    end

    // operand selection per state
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sh  = 1'b0;
        add_sel = ADD_ZERO;
        unique case (state_reg)
            pbfs_pkg::S_FC2:
            begin
                mul_a = AW'($signed({1'b0, fc_reg}));
                mul_b = BW'($signed({1'b0, fc_reg}));
            end
            pbfs_pkg::S_FC3:
            begin
                mul_a = AW'($signed({1'b0, acc_reg[25:0]}));
                mul_b = BW'($signed({1'b0, fc_reg}));
            end
            pbfs_pkg::S_DYN0:
            begin
                mul_a = AW'($signed({1'b0, meas_reg}) - $signed({1'b0, power_a_reg}));
                mul_b = BW'($signed({1'b0, den}));
            end
            pbfs_pkg::S_DYN1:
            begin
                mul_a   = AW'(dpp);
                mul_b   = BW'(neg_slope(fc_reg, freq_a_reg, d_zero, d_neg));
                add_sel = ADD_ACC;
            end
            pbfs_pkg::S_BASE:
            begin
                mul_a = AW'($signed({1'b0, budget_reg}) - $signed({1'b0, power_a_reg}));
                mul_b = BW'($signed({1'b0, den}));
            end
            pbfs_pkg::S_F2:
            begin
                mul_a = AW'($signed({1'b0, f_cur}));
                mul_b = BW'($signed({1'b0, f_cur}));
            end
            pbfs_pkg::S_F3:
            begin
                mul_a = AW'($signed({1'b0, acc_reg[25:0]}));
                mul_b = BW'($signed({1'b0, f_cur}));
            end
            pbfs_pkg::S_ROOM:
            begin
                mul_a   = AW'(dpp);
                mul_b   = BW'(neg_slope(f_cur, freq_a_reg, d_zero, d_neg));
                add_sel = ADD_BASE;
            end
            pbfs_pkg::S_L0:
            begin
                mul_a = AW'($signed({1'b0, dyn_reg}));
                mul_b = BW'($signed({1'b0, f3_reg[SH-1:0]}));
            end
            pbfs_pkg::S_L1:
            begin
                mul_a   = AW'($signed({1'b0, dyn_reg}));
                mul_b   = BW'($signed({1'b0, f3_reg[38:SH]}));
                mul_sh  = 1'b1;
                add_sel = ADD_ACC;
            end
            pbfs_pkg::S_R0:
            begin
                mul_a = AW'($signed({1'b0, room_reg}));
                mul_b = BW'($signed({1'b0, fc3_reg[SH-1:0]}));
            end
            pbfs_pkg::S_R1:
            begin
                mul_a   = AW'($signed({1'b0, room_reg}));
                mul_b   = BW'($signed({1'b0, fc3_reg[38:SH]}));
                mul_sh  = 1'b1;
                add_sel = ADD_ACC;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    logic in_fire, grid_done, room_neg, fits, out_free;
    assign s_axis_tready = (state_reg == pbfs_pkg::S_IDLE);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign grid_done = (k_reg == K_LAST) || (f_reg > {2'b00, max_reg});
    assign room_neg  = mac_res[CW-1];
    assign fits      = (lhs_reg <= mac_res);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbfs_pkg::S_IDLE: if (in_fire) state_next = pbfs_pkg::S_FC2;
            pbfs_pkg::S_FC2:  state_next = pbfs_pkg::S_FC3;
            pbfs_pkg::S_FC3:  state_next = pbfs_pkg::S_DYN0;
            pbfs_pkg::S_DYN0: state_next = pbfs_pkg::S_DYN1;
            pbfs_pkg::S_DYN1: state_next = pbfs_pkg::S_BASE;
            pbfs_pkg::S_BASE: state_next = pbfs_pkg::S_CHK;
            pbfs_pkg::S_CHK:  state_next = grid_done ? pbfs_pkg::S_OUT : pbfs_pkg::S_F2;
            pbfs_pkg::S_F2:   state_next = pbfs_pkg::S_F3;
            pbfs_pkg::S_F3:   state_next = pbfs_pkg::S_ROOM;
            pbfs_pkg::S_ROOM: state_next = room_neg ? pbfs_pkg::S_CHK : pbfs_pkg::S_L0;
            pbfs_pkg::S_L0:   state_next = pbfs_pkg::S_L1;
            pbfs_pkg::S_L1:   state_next = pbfs_pkg::S_R0;
            pbfs_pkg::S_R0:   state_next = pbfs_pkg::S_R1;
            pbfs_pkg::S_R1:   state_next = pbfs_pkg::S_CHK;
            pbfs_pkg::S_OUT:  if (out_free) state_next = pbfs_pkg::S_IDLE;
            default:          state_next = pbfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pbfs_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath captures
    logic [FW-1:0] step_eff, clamp_cap, clamp_out;
    assign step_eff  = (step_reg == '0) ? FW'(1) : step_reg;
    assign clamp_cap = (chosen_reg > cap_reg) ? cap_reg : chosen_reg;
    assign clamp_out = (clamp_cap < min_reg) ? min_reg : clamp_cap;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pbfs_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    fc_reg     <= (s_axis_tdata[12:0] == '0) ? FW'(1) : s_axis_tdata[12:0];
                    meas_reg   <= s_axis_tdata[32:13];
                    budget_reg <= s_axis_tdata[52:33];
                end
            end
            pbfs_pkg::S_FC2:  acc_reg <= mac_res;
            pbfs_pkg::S_FC3:  fc3_reg <= mac_res[38:0];
            pbfs_pkg::S_DYN0: acc_reg <= mac_res;
            pbfs_pkg::S_DYN1: dyn_reg <= mac_res[CW-1] ? '0 : mac_res[36:0];
            pbfs_pkg::S_BASE:
            begin
                base_reg   <= mac_res[35:0];
                f_reg      <= {2'b00, min_reg};
                k_reg      <= '0;
                chosen_reg <= min_reg;
                met_reg    <= 1'b0;
            end
            pbfs_pkg::S_F2: acc_reg <= mac_res;
            pbfs_pkg::S_F3: f3_reg  <= mac_res[38:0];
            pbfs_pkg::S_ROOM:
            begin
                room_reg <= mac_res[36:0];
                if (room_neg)
                begin
                    f_reg <= f_reg + {2'b00, step_eff};
                    k_reg <= k_reg + K_W'(1);
                end
            end
            pbfs_pkg::S_L0: acc_reg <= mac_res;
            pbfs_pkg::S_L1: lhs_reg <= mac_res;
            pbfs_pkg::S_R0: acc_reg <= mac_res;
            pbfs_pkg::S_R1:
            begin
                if (fits)
                begin
                    chosen_reg <= f_cur;
                    met_reg    <= 1'b1;
                end
                f_reg <= f_reg + {2'b00, step_eff};
                k_reg <= k_reg + K_W'(1);
            end
            pbfs_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_freq_reg <= clamp_out;
                    out_met_reg  <= met_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == pbfs_pkg::S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_freq_reg};
    assign m_axis_tuser  = out_met_reg;

endmodule
`default_nettype wire

// ===== tb/tb_power_budget_frequency_select.sv =====
`default_nettype none
module tb_power_budget_frequency_select;

    typedef struct packed {
        logic [pbfs_pkg::FREQ_W-1:0] freq;
        logic                        met;
    } pick_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pbfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pbfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [55:0]                     s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [15:0]                     m_axis_tdata;
    logic [0:0]                      m_axis_tuser;

    // local copy of the register file
    logic [pbfs_pkg::CFG_DATA_W-1:0] regs [8];

    logic [55:0] pending_beats [$];
    pick_t       expected_picks [$];
    int          errors = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          in_taken = 0;
    bit          quiet = 0;

    power_budget_frequency_select u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    // static power at f scaled by den, from the two calibration points
    function automatic longint static_line(input longint f, output longint den);
        longint fa, fb, pa, pb, d, num;
        fa = longint'(regs[pbfs_pkg::REG_FREQ_A]);
        fb = longint'(regs[pbfs_pkg::REG_FREQ_B]);
        pa = longint'(regs[pbfs_pkg::REG_POWER_A]);
        pb = longint'(regs[pbfs_pkg::REG_POWER_B]);
        d = fb - fa;
        if (d == 0)
        begin
            den = 1;
            return pa;
        end
        num = pa * d + (pb - pa) * (f - fa);
        if (d < 0)
        begin
            num = -num;
            d = -d;
        end
        den = d;
        return num;
    endfunction

    // highest grid frequency whose predicted power fits the budget
    function automatic pick_t best_freq(input logic [55:0] beat);
        longint fc, meas, budget, stp, den, dyn, f, s_f, room, lo, hi, cap;
        logic [127:0] lhs, rhs;
        pick_t p;
        fc = longint'(beat[12:0]);
        meas = longint'(beat[32:13]);
        budget = longint'(beat[52:33]);
        lo = longint'(regs[pbfs_pkg::REG_MIN]);
        hi = longint'(regs[pbfs_pkg::REG_MAX]);
        cap = longint'(regs[pbfs_pkg::REG_CAP]);
        stp = longint'(regs[pbfs_pkg::REG_STEP]);
        if (stp == 0) stp = 1;
        if (fc == 0) fc = 1;
        p.freq = regs[pbfs_pkg::REG_MIN][pbfs_pkg::FREQ_W-1:0];
        p.met = 1'b0;
        dyn = static_line(fc, den);
        dyn = meas * den - dyn;
        if (dyn < 0) dyn = 0;
        for (int k = 0; k < pbfs_pkg::DEFAULT_MAX_STEPS; k++)
        begin
            f = lo + k * stp;
            if (f > hi) break;
            s_f = static_line(f, den);
            room = budget * den - s_f;
            if (room < 0) continue;
            lhs = 128'(dyn) * 128'(f * f * f);
            rhs = 128'(room) * 128'(fc * fc * fc);
            if (lhs <= rhs)
            begin
                p.freq = f[pbfs_pkg::FREQ_W-1:0];
                p.met = 1'b1;
            end
        end
        if (longint'(p.freq) > cap) p.freq = cap[pbfs_pkg::FREQ_W-1:0];
        if (longint'(p.freq) < lo) p.freq = lo[pbfs_pkg::FREQ_W-1:0];
        return p;
    endfunction

    // input driver
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || in_taken)
        begin
            in_taken = 0;
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                s_axis_tdata <= pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 9);
        end
    end

    // monitor: predict on input beats, check result beats
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_picks.push_back(best_freq(s_axis_tdata));
            in_taken = 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_picks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat freq=%0d met=%0b", $time,
                         m_axis_tdata[12:0], m_axis_tuser[0]);
            end
            else
            begin
                want = expected_picks.pop_front();
                if (m_axis_tdata[12:0] !== want.freq)
                begin
                    errors++;
                    $display("%0t: chosen_freq_mhz expected %0d actual %0d", $time,
                             want.freq, m_axis_tdata[12:0]);
                end
                if (m_axis_tuser[0] !== want.met)
                begin
                    errors++;
                    $display("%0t: budget_met expected %0b actual %0b", $time,
                             want.met, m_axis_tuser[0]);
                end
            end
        end
    end

    task automatic write_reg(input pbfs_pkg::reg_idx_t idx,
                             input logic [pbfs_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == pbfs_pkg::REG_POWER_A || idx == pbfs_pkg::REG_POWER_B)
            regs[idx] = val;
        else
            regs[idx] = {7'd0, val[pbfs_pkg::FREQ_W-1:0]};
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_beat(input logic [12:0] fc, input logic [19:0] meas,
                              input logic [19:0] bud);
        pending_beats.push_back({3'd0, bud, meas, fc});
    endtask

    task automatic drain;
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_picks.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_all(input logic [12:0] fa, input logic [19:0] pa,
                           input logic [12:0] fb, input logic [19:0] pb,
                           input logic [12:0] lo, input logic [12:0] hi,
                           input logic [12:0] stp, input logic [12:0] cap);
        write_reg(pbfs_pkg::REG_FREQ_A, {7'd0, fa});
        write_reg(pbfs_pkg::REG_POWER_A, pa);
        write_reg(pbfs_pkg::REG_FREQ_B, {7'd0, fb});
        write_reg(pbfs_pkg::REG_POWER_B, pb);
        write_reg(pbfs_pkg::REG_MIN, {7'd0, lo});
        write_reg(pbfs_pkg::REG_MAX, {7'd0, hi});
        write_reg(pbfs_pkg::REG_STEP, {7'd0, stp});
        write_reg(pbfs_pkg::REG_CAP, {7'd0, cap});
    endtask

    // random beats: mostly measured/budget in a related range, some raw noise
    task automatic queue_random(input int n);
        logic [12:0] fc;
        logic [19:0] meas, bud;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                fc = 13'($urandom);
                meas = 20'($urandom);
                bud = 20'($urandom);
            end
            else
            begin
                fc = 13'($urandom_range(1, 8191));
                meas = 20'($urandom_range(0, 20000));
                bud = $urandom_range(0, 3) == 0 ? 20'(meas + $urandom_range(0, 20000))
                                                : 20'($urandom_range(0, 40000));
            end
            queue_beat(fc, meas, bud);
        end
    endtask

    initial
    begin
        regs[pbfs_pkg::REG_FREQ_A] = {7'd0, pbfs_pkg::RST_FREQ_A};
        regs[pbfs_pkg::REG_POWER_A] = pbfs_pkg::RST_POWER_A;
        regs[pbfs_pkg::REG_FREQ_B] = {7'd0, pbfs_pkg::RST_FREQ_B};
        regs[pbfs_pkg::REG_POWER_B] = pbfs_pkg::RST_POWER_B;
        regs[pbfs_pkg::REG_MIN] = {7'd0, pbfs_pkg::RST_MIN};
        regs[pbfs_pkg::REG_MAX] = {7'd0, pbfs_pkg::RST_MAX};
        regs[pbfs_pkg::REG_STEP] = {7'd0, pbfs_pkg::RST_STEP};
        regs[pbfs_pkg::REG_CAP] = {7'd0, pbfs_pkg::RST_CAP};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset configuration
        queue_beat(13'd0, 20'd0, 20'd0);
        queue_beat(13'd8191, 20'hFFFFF, 20'hFFFFF);
        queue_beat(13'd1, 20'hFFFFF, 20'd0);
        queue_beat(13'd1, 20'd0, 20'hFFFFF);
        queue_beat(13'd1000, 20'd2048, 20'd2048);
        queue_beat(13'd2000, 20'd3000, 20'd5000);
        queue_beat(13'd4000, 20'd1024, 20'd1024);
        queue_beat(13'd4000, 20'd10000, 20'd1500);
        queue_beat(13'd8191, 20'd0, 20'd700);
        queue_beat(13'd3000, 20'd5000, 20'd4000);
        queue_beat(13'd1500, 20'd800, 20'd600);
        queue_beat(13'h1555, 20'hAAAAA, 20'h55555);
        queue_beat(13'h0AAA, 20'h55555, 20'hAAAAA);
        drain();
        queue_random(150);
        drain();

        // widest grid, step of one
        set_all(13'd1, 20'd0, 13'd8191, 20'hFFFFF, 13'd1, 13'd8191, 13'd1, 13'd8191);
        queue_beat(13'd0, 20'd5, 20'd10);
        queue_beat(13'd8191, 20'hFFFFF, 20'hFFFFF);
        queue_random(150);
        drain();

        // equal calibration points, step zero, cap below minimum
        set_all(13'd2000, 20'd300, 13'd2000, 20'd900, 13'd3000, 13'd8000, 13'd0, 13'd2500);
        queue_random(150);
        drain();

        // falling static line, extrapolation below zero; swapped points
        set_all(13'd5000, 20'd100, 13'd1000, 20'd20000, 13'd500, 13'd8191, 13'd8191, 13'd8191);
        queue_random(150);
        drain();
        set_all(13'd1000, 20'd9000, 13'd1200, 20'd100, 13'd200, 13'd7000, 13'd150, 13'd6000);
        queue_random(150);
        drain();

        // minimum above maximum, and zero minimum and cap
        set_all(13'd1000, 20'd500, 13'd3000, 20'd1500, 13'd5000, 13'd4000, 13'd100, 13'd8000);
        queue_random(60);
        drain();
        set_all(13'd1, 20'd0, 13'd2, 20'd0, 13'd0, 13'd3000, 13'd50, 13'd0);
        queue_random(60);
        drain();

        // random configurations with small grids mostly
        for (int ph = 0; ph < 5; ph++)
        begin
            set_all(13'($urandom), 20'($urandom), 13'($urandom),
                    20'($urandom_range(0, 60000)),
                    13'($urandom_range(0, 4000)), 13'($urandom_range(0, 8191)),
                    13'($urandom_range(1, 500)), 13'($urandom));
            if (ph == 4) quiet = 1;
            queue_random(130);
            drain();
        end

        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
